/* hdl/pic_pkg.sv */
// Shared types, codes and constants of the platform interrupt controller.
`timescale 1ns / 1ps
`default_nettype none
package pic_pkg;

  localparam int NUM_SOURCES_DEF = 32;
  localparam int NUM_HARTS_DEF   = 2;
  localparam int FIFO_DEPTH_DEF  = 2;

  localparam int KIND_W      = 2;
  localparam int OFF_W       = 22;
  localparam int DATA_W      = 32;
  localparam int SRC_FIELD_W = 5;
  localparam int IRQ_W       = 4;
  localparam int PRIO_W      = 3;
  localparam int PRIO_LEVELS = 8;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEVEL = 2'd2;

  localparam logic [OFF_W-1:0] PEND_BASE = 22'h001000;
  localparam logic [OFF_W-1:0] EN_BASE   = 22'h002000;
  localparam logic [OFF_W-1:0] CTX_BASE  = 22'h200000;
  localparam int EN_STRIDE_LOG  = 7;
  localparam int CTX_STRIDE_LOG = 12;
  localparam logic [CTX_STRIDE_LOG-1:0] THR_REG   = 12'h000;
  localparam logic [CTX_STRIDE_LOG-1:0] CLAIM_REG = 12'h004;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_RD_PRIO,
    CMD_WR_PRIO,
    CMD_RD_PEND,
    CMD_RD_EN,
    CMD_WR_EN,
    CMD_RD_THR,
    CMD_WR_THR,
    CMD_CLAIM,
    CMD_COMPLETE,
    CMD_LEVEL
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic resp;
  } back_status_t;

endpackage
`default_nettype wire

/* hdl/pic_front.sv */
// Front end: decodes one transaction into a register command.
`timescale 1ns / 1ps
`default_nettype none
module pic_front import pic_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int NUM_HARTS   = NUM_HARTS_DEF
) (
  input  wire logic [KIND_W-1:0]      kind_i,
  input  wire logic [OFF_W-1:0]       offset_i,
  input  wire logic [DATA_W-1:0]      write_data_i,
  input  wire logic [SRC_FIELD_W-1:0] source_i,
  input  wire logic                   level_i,
  output cmd_t                        cmd_o
);

  localparam int CTX_COUNT = 2 * NUM_HARTS;

  logic [OFF_W-3:0] prio_idx;
  logic [OFF_W-1:0] en_rel;
  logic [OFF_W-1:0] ctx_rel;
  logic [OFF_W-EN_STRIDE_LOG-1:0]  en_ctx;
  logic [OFF_W-CTX_STRIDE_LOG-1:0] ctx_ctx;
  logic is_read;

  assign prio_idx = offset_i[OFF_W-1:2];
  assign en_rel   = offset_i - EN_BASE;
  assign ctx_rel  = offset_i - CTX_BASE;
  assign en_ctx   = en_rel[OFF_W-1:EN_STRIDE_LOG];
  assign ctx_ctx  = ctx_rel[OFF_W-1:CTX_STRIDE_LOG];
  assign is_read  = (kind_i == KIND_READ);

  always_comb begin
    cmd_o.op   = CMD_NOP;
    cmd_o.idx  = '0;
    cmd_o.data = write_data_i;
    if (kind_i == KIND_LEVEL) begin
      if (source_i != '0 && 32'(source_i) < 32'(NUM_SOURCES)) begin
        cmd_o.op   = CMD_LEVEL;
        cmd_o.idx  = IDX_W'(source_i);
        cmd_o.data = DATA_W'(level_i);
      end
    end else if (kind_i == KIND_READ || kind_i == KIND_WRITE) begin
      priority if (offset_i < PEND_BASE) begin
        cmd_o.idx = prio_idx[IDX_W-1:0];
        if (32'(prio_idx) < 32'(NUM_SOURCES)) begin
          if (is_read) begin
            cmd_o.op = CMD_RD_PRIO;
          end else if (prio_idx != '0) begin
            cmd_o.op = CMD_WR_PRIO;
          end
        end
      end else if (offset_i < EN_BASE) begin
        if (is_read && offset_i == PEND_BASE) begin
          cmd_o.op = CMD_RD_PEND;
        end
      end else if (offset_i < CTX_BASE) begin
        cmd_o.idx = en_ctx[IDX_W-1:0];
        if (32'(en_ctx) < 32'(CTX_COUNT) && en_rel[EN_STRIDE_LOG-1:0] == '0) begin
          cmd_o.op = is_read ? CMD_RD_EN : CMD_WR_EN;
        end
      end else begin
        cmd_o.idx = ctx_ctx[IDX_W-1:0];
        if (32'(ctx_ctx) < 32'(CTX_COUNT)) begin
          if (ctx_rel[CTX_STRIDE_LOG-1:0] == THR_REG) begin
            cmd_o.op = is_read ? CMD_RD_THR : CMD_WR_THR;
          end else if (ctx_rel[CTX_STRIDE_LOG-1:0] == CLAIM_REG) begin
            if (is_read) begin
              cmd_o.op = CMD_CLAIM;
            end else if (write_data_i != '0 && write_data_i < 32'(NUM_SOURCES)) begin
              // complete carries the source number in the index
              cmd_o.op  = CMD_COMPLETE;
              cmd_o.idx = write_data_i[IDX_W-1:0];
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/pic_fifo.sv */
// Short command queue between the decode front and the execute back.
`timescale 1ns / 1ps
`default_nettype none
module pic_fifo import pic_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/pic_back.sv */
// Execute back end: register state, claim arbitration and the result register.
`timescale 1ns / 1ps
`default_nettype none
module pic_back import pic_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int NUM_HARTS   = NUM_HARTS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         cmd_i,
  input  wire logic         cmd_valid_i,
  output back_status_t      status_o,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic [IRQ_W-1:0]  irq_lines_o
);

  localparam int CTX_COUNT = 2 * NUM_HARTS;
  localparam int SRC_W     = $clog2(NUM_SOURCES);
  localparam int CTX_W     = $clog2(CTX_COUNT);
  localparam int IRQ_CTX   = (CTX_COUNT < IRQ_W) ? CTX_COUNT : IRQ_W;
  localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

  localparam logic ST_EXEC = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic [PRIO_W-1:0]      prio_q [NUM_SOURCES];
  logic [PRIO_W-1:0]      prio_d [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] en_q   [CTX_COUNT];
  logic [NUM_SOURCES-1:0] en_d   [CTX_COUNT];
  logic [PRIO_W-1:0]      thr_q  [CTX_COUNT];
  logic [PRIO_W-1:0]      thr_d  [CTX_COUNT];
  logic [NUM_SOURCES-1:0] line_q, line_d;
  logic [NUM_SOURCES-1:0] served_q, served_d;
  logic                   phase_q, phase_d;
  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      rdata_q, rdata_d;
  logic [DATA_W-1:0]      out_rdata_q;
  logic [IRQ_W-1:0]       out_irq_q;

  logic [NUM_SOURCES-1:0] pending;
  logic [NUM_SOURCES-1:0] cand;
  logic [NUM_SOURCES-1:0] hit;
  logic [NUM_SOURCES-1:0] lvl_vec [PRIO_LEVELS];
  logic [NUM_SOURCES-1:0] best_vec;
  logic [NUM_SOURCES-1:0] low_vec;
  logic [SRC_W-1:0]       claim_id;
  logic                   claim_any;
  logic [NUM_SOURCES-1:0] gt_vec [IRQ_CTX];
  logic [IRQ_W-1:0]       irq_now;
  logic [CTX_W-1:0]       ctx;
  logic [SRC_W-1:0]       src;
  logic                   exec_fire;
  logic                   load_out;

  assign pending = line_q & ~served_q & SRC_MASK;
  assign ctx     = cmd_i.idx[CTX_W-1:0];
  assign src     = cmd_i.idx[SRC_W-1:0];

  // claim arbitration: bucket candidates by priority, take the top bucket,
  // then its lowest source
  always_comb begin
    cand = pending & en_q[ctx];
    for (int s = 0; s < NUM_SOURCES; s++) begin
      hit[s] = cand[s] && (prio_q[s] > thr_q[ctx]);
    end
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        lvl_vec[p][s] = hit[s] && (prio_q[s] == PRIO_W'(p));
      end
    end
    best_vec = '0;
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      if (|lvl_vec[p]) begin
        best_vec = lvl_vec[p];
      end
    end
    low_vec   = best_vec & (~best_vec + 1'b1);
    claim_any = |best_vec;
    claim_id  = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      for (int b = 0; b < SRC_W; b++) begin
        if (((s >> b) & 1) == 1) begin
          claim_id[b] = claim_id[b] | low_vec[s];
        end
      end
    end
  end

  always_comb begin
    irq_now = '0;
    for (int c = 0; c < IRQ_CTX; c++) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        gt_vec[c][s] = prio_q[s] > thr_q[c];
      end
      irq_now[c] = |(pending & en_q[c] & gt_vec[c]);
    end
  end

  assign exec_fire = (phase_q == ST_EXEC) && cmd_valid_i;
  assign load_out  = (phase_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    prio_d      = prio_q;
    en_d        = en_q;
    thr_d       = thr_q;
    line_d      = line_q;
    served_d    = served_q;
    rdata_d     = rdata_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      phase_d     = ST_EXEC;
    end
    if (exec_fire) begin
      phase_d = ST_RESP;
      rdata_d = '0;
      unique case (cmd_i.op)
        CMD_RD_PRIO: rdata_d = DATA_W'(prio_q[src]);
        CMD_WR_PRIO: prio_d[src] = cmd_i.data[PRIO_W-1:0];
        CMD_RD_PEND: rdata_d = DATA_W'(pending);
        CMD_RD_EN:   rdata_d = DATA_W'(en_q[ctx]);
        CMD_WR_EN:   en_d[ctx] = cmd_i.data[NUM_SOURCES-1:0] & SRC_MASK;
        CMD_RD_THR:  rdata_d = DATA_W'(thr_q[ctx]);
        CMD_WR_THR:  thr_d[ctx] = cmd_i.data[PRIO_W-1:0];
        CMD_CLAIM: begin
          if (claim_any) begin
            rdata_d            = DATA_W'(claim_id);
            served_d[claim_id] = 1'b1;
          end
        end
        CMD_COMPLETE: served_d[src] = 1'b0;
        CMD_LEVEL:    line_d[src] = cmd_i.data[0];
        default: begin
          rdata_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q      <= '{default: '0};
      en_q        <= '{default: '0};
      thr_q       <= '{default: '0};
      line_q      <= '0;
      served_q    <= '0;
      phase_q     <= ST_EXEC;
      out_valid_q <= 1'b0;
    end else begin
      prio_q      <= prio_d;
      en_q        <= en_d;
      thr_q       <= thr_d;
      line_q      <= line_d;
      served_q    <= served_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // irq lines sample the state after the executed command took effect
  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    if (load_out) begin
      out_rdata_q <= rdata_q;
      out_irq_q   <= irq_now;
    end
  end

  assign status_o.pop  = exec_fire;
  assign status_o.resp = (phase_q == ST_RESP);
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rdata_q;
  assign irq_lines_o   = out_irq_q;

endmodule
`default_nettype wire

/* hdl/platform_interrupt_controller.sv */
// Top level of the platform interrupt controller: decode, command queue, execute.
// A transaction is queued, executed into the result register, then loaded into
// the output register once it is free; the back end executes a new command only
// after the last result has moved out, and the queue keeps accepting while a result waits.
// Reset: rst_ni clears all priorities, enables, thresholds, line levels and
// served marks at once, asynchronously; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module platform_interrupt_controller import pic_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int NUM_HARTS   = NUM_HARTS_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // offset[21:0], write_data[53:22], source[58:54], level[59], zero[63:60]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  wire logic [KIND_W-1:0]      s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // read_data[31:0], irq_lines[35:32], zero[39:36]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  cmd_t              front_cmd;
  cmd_t              queue_cmd;
  logic              fifo_full;
  logic              fifo_empty;
  logic              fifo_push;
  back_status_t      back_status;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  irq_lines;

  assign s_axis_tready_o = !fifo_full;
  assign fifo_push       = s_axis_tvalid_i && !fifo_full;

  pic_front #(
    .NUM_SOURCES(NUM_SOURCES),
    .NUM_HARTS  (NUM_HARTS)
  ) u_front (
    .kind_i      (s_axis_tuser_i),
    .offset_i    (s_axis_tdata_i[OFF_W-1:0]),
    .write_data_i(s_axis_tdata_i[OFF_W+DATA_W-1:OFF_W]),
    .source_i    (s_axis_tdata_i[OFF_W+DATA_W+SRC_FIELD_W-1:OFF_W+DATA_W]),
    .level_i     (s_axis_tdata_i[OFF_W+DATA_W+SRC_FIELD_W]),
    .cmd_o       (front_cmd)
  );

  pic_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .data_i (front_cmd),
    .pop_i  (back_status.pop),
    .data_o (queue_cmd),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  pic_back #(
    .NUM_SOURCES(NUM_SOURCES),
    .NUM_HARTS  (NUM_HARTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (queue_cmd),
    .cmd_valid_i(!fifo_empty),
    .status_o   (back_status),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .read_data_o(read_data),
    .irq_lines_o(irq_lines)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W-DATA_W-IRQ_W){1'b0}}, irq_lines, read_data};

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |-> !fifo_empty)
    else $error("command popped from an empty queue");

  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |=> back_status.resp)
    else $error("executed command did not move to response");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_full && !back_status.pop) |=> fifo_full)
    else $error("queue lost an entry without a pop");

endmodule
`default_nettype wire
